/* rtl/ptts_pkg.sv */
// Shared widths, codes and bundle types for the periodic task tick scheduler.
package ptts_pkg;

  // Field widths.
  localparam int W_REQ    = 2;
  localparam int W_SLOT   = 4;
  localparam int W_TIME   = 12;
  localparam int W_DL     = 13;
  localparam int W_KEY    = 14;
  localparam int W_POLICY = 2;
  localparam int W_TCNT   = 5;
  localparam int W_CFG_IDX  = 1;
  localparam int W_CFG_DATA = 5;

  // Default number of task slots.
  localparam int DEFAULT_MAX_TASKS = 16;

  // Request codes.
  localparam logic [W_REQ-1:0] REQ_LOAD    = 2'd0;
  localparam logic [W_REQ-1:0] REQ_RESTART = 2'd1;
  localparam logic [W_REQ-1:0] REQ_TICK    = 2'd2;

  // Scheduling policy codes.
  localparam logic [W_POLICY-1:0] POL_RMS = 2'd0;
  localparam logic [W_POLICY-1:0] POL_EDF = 2'd1;
  localparam logic [W_POLICY-1:0] POL_LLF = 2'd2;
  localparam logic [W_POLICY-1:0] POL_DMS = 2'd3;

  // Configuration register indexes.
  localparam logic [W_CFG_IDX-1:0] CFG_POLICY     = 1'b0;
  localparam logic [W_CFG_IDX-1:0] CFG_TASK_COUNT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [W_POLICY-1:0] POLICY_RESET     = POL_RMS;
  localparam logic [W_TCNT-1:0]   TASK_COUNT_RESET = 5'd1;

  // Deadline countdown floor (most negative 13-bit value).
  localparam logic signed [W_DL-1:0] DL_MIN = 13'sh1000;

  // One task table entry.
  typedef struct packed {
    logic [W_TIME-1:0] exec_time;
    logic [W_TIME-1:0] period;
    logic [W_TIME-1:0] rel_deadline;
  } entry_t;

  // Operands for the shared slot unit.
  typedef struct packed {
    logic [W_POLICY-1:0]     policy;
    entry_t                  tab;
    logic [W_TIME-1:0]       rw;
    logic [W_TIME-1:0]       rc;
    logic signed [W_DL-1:0]  dl;
    logic                    found;
    logic signed [W_KEY-1:0] best_key;
  } alu_in_t;

  // Results of the shared slot unit.
  typedef struct packed {
    logic [W_TIME-1:0]       rw_next;
    logic [W_TIME-1:0]       rc_next;
    logic signed [W_DL-1:0]  dl_next;
    logic signed [W_KEY-1:0] key;
    logic                    take;
  } alu_out_t;

endpackage

/* rtl/ptts_ifc.sv */
// Request and result channel interfaces of the periodic task tick scheduler.
interface ptts_req_if;
  logic                            valid;
  logic                            ready;
  logic [ptts_pkg::W_REQ-1:0]      req_type;
  logic [ptts_pkg::W_SLOT-1:0]     task_slot;
  logic [ptts_pkg::W_TIME-1:0]     exec_time;
  logic [ptts_pkg::W_TIME-1:0]     period;
  logic [ptts_pkg::W_TIME-1:0]     rel_deadline;

  modport source (
    output valid, req_type, task_slot, exec_time, period, rel_deadline,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_slot, exec_time, period, rel_deadline,
    output ready
  );
endinterface

interface ptts_res_if;
  logic                        valid;
  logic                        ready;
  logic                        busy_res;
  logic [ptts_pkg::W_SLOT-1:0] chosen_slot;

  modport source (
    output valid, busy_res, chosen_slot,
    input  ready
  );
  modport sink (
    input  valid, busy_res, chosen_slot,
    output ready
  );
endinterface

/* rtl/periodic_task_tick_scheduler_top.sv */
// Top level of the periodic task tick scheduler: sequencer, run state and channels.
//
// Usage: requests arrive on the req channel (valid/ready). A load transaction
// writes one task slot's execution time, period and relative deadline as it
// is accepted. A restart transaction sweeps all MAX_TASKS slots, one per cycle,
// clearing remaining work and release countdowns and setting each deadline
// countdown to the slot's period; the block is busy through its scan, drain
// and finish states and gives no result. A tick transaction walks the active
// slots through one shared slot unit, one slot per cycle behind the registered
// task memory read, then decrements the winner's remaining work. Its result
// is registered as the tick leaves its finish state; with no active slot the
// scan and drain are skipped and the tick goes straight to the finish state.
// The block is not ready while a restart or tick is in progress.
// The result sits in an output register; the next request is accepted while
// it waits, and a later tick holds in its final cycle until the receiver
// takes the earlier result. Configuration writes (policy, task_count) are
// single-cycle writes and are meant only while the block is idle.
// Reset clears the run state, sets policy to rate monotonic and task_count
// to one; task table entries are undefined until loaded.
module periodic_task_tick_scheduler_top #(
  parameter int MAX_TASKS = ptts_pkg::DEFAULT_MAX_TASKS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ptts_pkg::W_CFG_IDX-1:0]    cfg_index,
  input  logic [ptts_pkg::W_CFG_DATA-1:0]   cfg_wdata,
  ptts_req_if.sink                          req,
  ptts_res_if.source                        res
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int LIM_W = (CNT_W > ptts_pkg::W_TCNT) ? CNT_W : ptts_pkg::W_TCNT;
  localparam int EXT_W = 8;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [ptts_pkg::W_POLICY-1:0] policy;
  logic [ptts_pkg::W_TCNT-1:0]   task_count;

  // Run state.
  logic [ptts_pkg::W_TIME-1:0]       rw_arr [MAX_TASKS];
  logic [ptts_pkg::W_TIME-1:0]       rc_arr [MAX_TASKS];
  logic signed [ptts_pkg::W_DL-1:0]  dl_arr [MAX_TASKS];

  // Sequencer registers.
  logic                              is_tick;
  logic [LIM_W-1:0]                  rd_idx;
  logic [LIM_W-1:0]                  scan_limit;
  logic                              p_valid;
  logic [IDX_W-1:0]                  p_idx;
  logic                              found;
  logic [IDX_W-1:0]                  best;
  logic signed [ptts_pkg::W_KEY-1:0] best_key;

  // Result register.
  logic                              res_valid;
  logic                              res_busy;
  logic [ptts_pkg::W_SLOT-1:0]       res_slot;

  logic                              in_fire;
  logic                              out_fire;
  logic                              finish_go;
  logic                              mem_we;
  logic [EXT_W-1:0]                  slot_ext;
  logic [EXT_W-1:0]                  best_ext;
  logic [LIM_W-1:0]                  max_ext;
  logic [LIM_W-1:0]                  tc_ext;
  logic [LIM_W-1:0]                  n_active;
  logic [LIM_W-1:0]                  rd_idx_inc;
  ptts_pkg::entry_t                  wr_entry;
  ptts_pkg::entry_t                  rd_entry;
  ptts_pkg::alu_in_t                 alu_op;
  ptts_pkg::alu_out_t                alu_res;

  // Handshakes.
  assign req.ready = (state == ST_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign out_fire  = res_valid && res.ready;
  assign finish_go = (state == ST_FINISH) && (!is_tick || !res_valid || res.ready);

  // Active slot count, capped at MAX_TASKS.
  assign max_ext    = LIM_W'(MAX_TASKS);
  assign tc_ext     = LIM_W'(task_count);
  assign n_active   = (tc_ext > max_ext) ? max_ext : tc_ext;
  assign rd_idx_inc = rd_idx + 1'b1;

  // Load writes go straight into the task memory.
  assign slot_ext = EXT_W'(req.task_slot);
  assign mem_we   = in_fire && (req.req_type == ptts_pkg::REQ_LOAD) &&
                    (slot_ext < EXT_W'(MAX_TASKS));
  assign wr_entry.exec_time    = req.exec_time;
  assign wr_entry.period       = req.period;
  assign wr_entry.rel_deadline = req.rel_deadline;

  ptts_task_mem #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_ext[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // Shared slot unit, fed by the slot in the process stage.
  assign alu_op.policy   = policy;
  assign alu_op.tab      = rd_entry;
  assign alu_op.rw       = rw_arr[p_idx];
  assign alu_op.rc       = rc_arr[p_idx];
  assign alu_op.dl       = dl_arr[p_idx];
  assign alu_op.found    = found;
  assign alu_op.best_key = best_key;

  ptts_slot_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= ptts_pkg::POLICY_RESET;
      task_count <= ptts_pkg::TASK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ptts_pkg::CFG_POLICY:     policy     <= cfg_wdata[ptts_pkg::W_POLICY-1:0];
        ptts_pkg::CFG_TASK_COUNT: task_count <= cfg_wdata[ptts_pkg::W_TCNT-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      is_tick    <= 1'b0;
      rd_idx     <= '0;
      scan_limit <= '0;
      p_valid    <= 1'b0;
    end else begin
      p_valid <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          rd_idx <= '0;
          if (in_fire) begin
            case (req.req_type)
              ptts_pkg::REQ_RESTART: begin
                is_tick    <= 1'b0;
                scan_limit <= max_ext;
                state      <= ST_SCAN;
              end
              ptts_pkg::REQ_TICK: begin
                is_tick    <= 1'b1;
                scan_limit <= n_active;
                state      <= (n_active == '0) ? ST_FINISH : ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          rd_idx <= rd_idx_inc;
          if (rd_idx_inc == scan_limit) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Process stage index follows the memory read address in the next cycle.
  always_ff @(posedge clk) begin
    p_idx <= rd_idx[IDX_W-1:0];
  end

  // Best candidate tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (in_fire) begin
      found <= 1'b0;
    end else if (p_valid && is_tick && alu_res.take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && is_tick && alu_res.take) begin
      best     <= p_idx;
      best_key <= alu_res.key;
    end
  end

  // Run state updates: per-slot writeback during the scan, winner decrement at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        rw_arr[i] <= '0;
        rc_arr[i] <= '0;
        dl_arr[i] <= '0;
      end
    end else begin
      if (p_valid) begin
        if (is_tick) begin
          rw_arr[p_idx] <= alu_res.rw_next;
          rc_arr[p_idx] <= alu_res.rc_next;
          dl_arr[p_idx] <= alu_res.dl_next;
        end else begin
          rw_arr[p_idx] <= '0;
          rc_arr[p_idx] <= '0;
          dl_arr[p_idx] <= $signed({1'b0, rd_entry.period});
        end
      end
      if (finish_go && is_tick && found) begin
        rw_arr[best] <= rw_arr[best] - 1'b1;
      end
    end
  end

  // Result register.
  assign best_ext = EXT_W'(best);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish_go && is_tick) begin
      res_valid <= 1'b1;
    end else if (out_fire) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go && is_tick) begin
      res_busy <= found;
      res_slot <= found ? best_ext[ptts_pkg::W_SLOT-1:0] : '0;
    end
  end

  assign res.valid       = res_valid;
  assign res.busy_res    = res_busy;
  assign res.chosen_slot = res_slot;

endmodule

/* rtl/ptts_task_mem.sv */
// Task parameter memory: one write port, one registered read port.
module ptts_task_mem #(
  parameter int MAX_TASKS = ptts_pkg::DEFAULT_MAX_TASKS,
  parameter int IDX_W     = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  ptts_pkg::entry_t     wdata,
  input  logic [IDX_W-1:0]     raddr,
  output ptts_pkg::entry_t     rdata
);

  ptts_pkg::entry_t mem [MAX_TASKS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ptts_slot_alu.sv */
// Shared slot unit: release, aging, policy key and best-so-far compare for one slot.
module ptts_slot_alu (
  input  ptts_pkg::alu_in_t  op,
  output ptts_pkg::alu_out_t res
);

  logic                                  released;
  logic [ptts_pkg::W_TIME-1:0]           rw_rel;
  logic [ptts_pkg::W_TIME-1:0]           rc_rel;
  logic signed [ptts_pkg::W_DL-1:0]      dl_rel;
  logic signed [ptts_pkg::W_KEY-1:0]     dl_ext;
  logic signed [ptts_pkg::W_KEY-1:0]     key;

  // A slot whose release countdown ran out starts a new job.
  assign released = (op.rc == '0);
  assign rw_rel   = released ? op.tab.exec_time : op.rw;
  assign rc_rel   = released ? op.tab.period : op.rc;
  assign dl_rel   = released ? $signed({1'b0, op.tab.rel_deadline}) : op.dl;
  assign dl_ext   = $signed({dl_rel[ptts_pkg::W_DL-1], dl_rel});

  // Priority key under the active policy; lower wins.
  always_comb begin
    case (op.policy)
      ptts_pkg::POL_RMS: key = $signed({2'b00, op.tab.period});
      ptts_pkg::POL_EDF: key = dl_ext;
      ptts_pkg::POL_LLF: key = dl_ext - $signed({2'b00, rw_rel});
      ptts_pkg::POL_DMS: key = $signed({2'b00, op.tab.rel_deadline});
      default:           key = $signed({2'b00, op.tab.period});
    endcase
  end

  // Aged countdowns; the chosen slot's work is decremented after the scan.
  assign res.rw_next = rw_rel;
  assign res.rc_next = (rc_rel != '0) ? rc_rel - 1'b1 : rc_rel;
  assign res.dl_next = (dl_rel != ptts_pkg::DL_MIN) ? dl_rel - 1'b1 : dl_rel;
  assign res.key     = key;

  // Strictly lower key replaces the best, so ties keep the lower slot.
  assign res.take = (rw_rel != '0) && (!op.found || (key < op.best_key));

endmodule
